// ===== rtl/cfwd_pkg.sv =====
package cfwd_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Input item kinds
  localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd2;

  // Result actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_APPLY   = 2'd1;
  localparam logic [1:0] ACT_NEUTRAL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO_LIM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO_ON  = 2'd3;

  // Frame layout: header, four command bytes, checksum
  localparam int unsigned      NUM_CMD    = 4;
  localparam logic [POS_W-1:0] POS_HUNT   = 3'd0;
  localparam logic [POS_W-1:0] POS_CHKSUM = 3'd5;
  localparam logic [3:0]       NIBBLE_MASK = 4'hF;
  localparam logic [BYTE_W-1:0] ERR_MAX   = 8'd255;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [BYTE_W-1:0] cmd_x;
    logic signed [BYTE_W-1:0] cmd_y;
    logic signed [BYTE_W-1:0] cmd_z;
    logic signed [BYTE_W-1:0] cmd_yaw;
    logic [BYTE_W-1:0]        bad_frames;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] error_limit;
    logic [TMO_W-1:0]  timeout_limit_ms;
    logic              timeout_on;
  } cfg_t;

endpackage

// ===== rtl/cfwd_in_reg.sv =====
module cfwd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cfwd_pkg::item_t in_item,
  input  logic           advance,
  output logic           s1_valid,
  output cfwd_pkg::item_t s1_item
);
  import cfwd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  load;

  // Take a new transfer whenever the held item moves on or the stage is empty
  assign load     = advance || !valid_r;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = in_valid;
      item_nxt  = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== rtl/cfwd_core.sv =====
module cfwd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  cfwd_pkg::item_t   item,
  input  cfwd_pkg::cfg_t    cfg,
  output cfwd_pkg::result_t res
);
  import cfwd_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] frame_r [NUM_CMD];
  logic [BYTE_W-1:0] frame_nxt [NUM_CMD];
  logic [BYTE_W-1:0] err_r, err_nxt;
  logic              mark_r, mark_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] last_eff;
  logic [TIME_W-1:0] elapsed;
  logic [5:0]        nib_sum;

  assign nib_sum = {2'b00, frame_r[0][3:0] & NIBBLE_MASK}
                 + {2'b00, frame_r[1][3:0] & NIBBLE_MASK}
                 + {2'b00, frame_r[2][3:0] & NIBBLE_MASK}
                 + {2'b00, frame_r[3][3:0] & NIBBLE_MASK};

  // A pending good frame moves the reference time to now
  assign last_eff = mark_r ? time_r : last_r;
  assign elapsed  = time_r - last_eff;

  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    err_nxt   = err_r;
    mark_nxt  = mark_r;
    time_nxt  = time_r;
    last_nxt  = last_r;
    res       = '0;
    res.action = ACT_NONE;

    case (item.func)
      FUNC_BYTE: begin
        if (pos_r == POS_HUNT) begin
          if (item.rx_byte == cfg.header_value) begin
            pos_nxt = POS_HUNT + 3'd1;
          end
        end else if (pos_r < POS_CHKSUM) begin
          for (int i = 0; i < NUM_CMD; i++) begin
            if (pos_r == POS_W'(i + 1)) begin
              frame_nxt[i] = item.rx_byte;
            end
          end
          pos_nxt = pos_r + 3'd1;
        end else begin
          if ({2'b00, nib_sum} == item.rx_byte) begin
            res.action  = ACT_APPLY;
            res.cmd_x   = frame_r[0];
            res.cmd_y   = frame_r[1];
            res.cmd_z   = frame_r[2];
            res.cmd_yaw = frame_r[3];
            mark_nxt    = 1'b1;
            err_nxt     = '0;
          end else begin
            if (err_r != ERR_MAX) begin
              err_nxt = err_r + 8'd1;
            end
            if (err_nxt >= cfg.error_limit) begin
              res.action = ACT_NEUTRAL;
            end
          end
          pos_nxt = POS_HUNT;
        end
      end
      FUNC_TICK: begin
        time_nxt = time_r + 32'd1;
      end
      FUNC_POLL: begin
        mark_nxt = 1'b0;
        last_nxt = last_eff;
        if (cfg.timeout_on && (elapsed > {16'd0, cfg.timeout_limit_ms})) begin
          res.action = ACT_NEUTRAL;
          err_nxt    = '0;
          last_nxt   = time_r;
        end
      end
      default: begin
      end
    endcase

    res.bad_frames = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      err_r  <= '0;
      mark_r <= 1'b0;
      time_r <= '0;
      last_r <= '0;
    end else if (step_en) begin
      pos_r  <= pos_nxt;
      err_r  <= err_nxt;
      mark_r <= mark_nxt;
      time_r <= time_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      frame_r <= frame_nxt;
    end
  end

endmodule

// ===== rtl/cfwd_out_reg.sv =====
module cfwd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  cfwd_pkg::result_t res_in,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output cfwd_pkg::result_t res_out
);
  import cfwd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  // Advance a held item when the result slot is empty or its transfer completes now
  assign advance = s1_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (advance) begin
      valid_nxt = 1'b1;
      res_nxt   = res_in;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== rtl/command_frame_receiver_with_watchdog_unit.sv =====
// Channel   Ports                                       Direction
// input     in_valid, in_stall, in_func, in_rx_byte     item in
// result    out_valid, out_stall, out_action, out_cmd_*,
//           out_bad_frames                              result out
// config    cfg_we, cfg_idx, cfg_wdata                  register write
//
// One item per clock while out_stall is low; each item gives exactly one
// result, passing through the input register, then the result register.
// Between these two registers lies the combinational frame/watchdog
// step, whose longest path is the 32-bit elapsed-time subtract and compare.
// Reset (rst_n low, synchronous) hunts for a header with all counters zero.
// A stalled result holds; the input register still fills, then stalls.
module command_frame_receiver_with_watchdog_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cfwd_pkg::FUNC_W-1:0]      in_func,
  input  logic [cfwd_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_action,
  output logic signed [cfwd_pkg::BYTE_W-1:0] out_cmd_x,
  output logic signed [cfwd_pkg::BYTE_W-1:0] out_cmd_y,
  output logic signed [cfwd_pkg::BYTE_W-1:0] out_cmd_z,
  output logic signed [cfwd_pkg::BYTE_W-1:0] out_cmd_yaw,
  output logic [cfwd_pkg::BYTE_W-1:0]      out_bad_frames,
  input  logic                             cfg_we,
  input  logic [cfwd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cfwd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cfwd_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  item_t   in_item, s1_item;
  logic    s1_valid;
  logic    advance;
  result_t core_res, out_res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_HEADER:  cfg_nxt.header_value     = cfg_wdata[BYTE_W-1:0];
        CFG_ERR_LIM: cfg_nxt.error_limit      = cfg_wdata[BYTE_W-1:0];
        CFG_TMO_LIM: cfg_nxt.timeout_limit_ms = cfg_wdata[TMO_W-1:0];
        CFG_TMO_ON:  cfg_nxt.timeout_on       = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value     <= 8'd170;
      cfg_r.error_limit      <= 8'd3;
      cfg_r.timeout_limit_ms <= 16'd500;
      cfg_r.timeout_on       <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item.func    = in_func;
  assign in_item.rx_byte = in_rx_byte;

  cfwd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cfwd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  cfwd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_in    (core_res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (out_res)
  );

  assign out_action     = out_res.action;
  assign out_cmd_x      = out_res.cmd_x;
  assign out_cmd_y      = out_res.cmd_y;
  assign out_cmd_z      = out_res.cmd_z;
  assign out_cmd_yaw    = out_res.cmd_yaw;
  assign out_bad_frames = out_res.bad_frames;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_apply_clears_errors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_APPLY) |-> (out_bad_frames == '0))
    else $error("applied frame with nonzero error count");

  a_cmd_zero_unless_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != ACT_APPLY) |->
      (out_cmd_x == '0 && out_cmd_y == '0 && out_cmd_z == '0 && out_cmd_yaw == '0))
    else $error("command fields set without apply");

  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("stepped item produced no result");
`endif

endmodule
